FILE: rtl/dmxtx_pkg.sv
package dmxtx_pkg;

	localparam int MAX_CHANNELS = 512;
	localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	localparam logic [9:0] MAX_SLOTS = 10'(MAX_CHANNELS);
	localparam logic [3:0] BITS_PER_SLOT = 4'd11;
	localparam logic [7:0] START_CODE = 8'h00;

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam logic [2:0] CFG_BIT_TICKS   = 3'd0;
	localparam logic [2:0] CFG_BREAK_TICKS = 3'd1;
	localparam logic [2:0] CFG_MAB_TICKS   = 3'd2;
	localparam logic [2:0] CFG_AFTER_TICKS = 3'd3;
	localparam logic [2:0] CFG_SLOT_COUNT  = 3'd4;

	typedef struct packed {
		logic       action;
		logic [8:0] channel;
		logic [7:0] level;
	} in_item_t;

	typedef struct packed {
		logic       line;
		logic       frame_start;
		logic       slot_start;
		logic [9:0] slot_number;
	} out_item_t;

	typedef struct packed {
		logic             is_tick;
		logic             wr_en;
		logic [CH_AW-1:0] addr;
		logic [7:0]       level;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  bit_ticks;
		logic [15:0] break_ticks;
		logic [15:0] mab_ticks;
		logic [15:0] after_frame_ticks;
		logic [9:0]  slot_count;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic clearing;
	} back_ctrl_t;

endpackage

FILE: rtl/dmxtx_front.sv
module dmxtx_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  dmxtx_pkg::in_item_t   request,
	input  dmxtx_pkg::back_ctrl_t ctrl,
	output logic                  cmd_valid,
	output dmxtx_pkg::cmd_t       cmd
);

	dmxtx_pkg::cmd_t cmd_mem_q [4];
	dmxtx_pkg::cmd_t cmd_in;
	logic [1:0] wptr_q, rptr_q;
	logic [2:0] cnt_q;
	logic       accept;

	// classify: tick or write, and drop writes beyond the channel store
	always_comb begin
		cmd_in.is_tick = (request.action == dmxtx_pkg::ACT_TICK);
		cmd_in.wr_en   = ({1'b0, request.channel} < dmxtx_pkg::MAX_SLOTS);
		cmd_in.addr    = request.channel[dmxtx_pkg::CH_AW-1:0];
		cmd_in.level   = request.level;
	end

	assign full      = (cnt_q == 3'd4) || ctrl.clearing;
	assign accept    = push && !full;
	assign cmd_valid = (cnt_q != 3'd0);
	assign cmd       = cmd_mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_mem_q[wptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (accept) begin
				wptr_q <= wptr_q + 2'd1;
			end
			if (ctrl.take) begin
				rptr_q <= rptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b00, accept} - {2'b00, ctrl.take};
		end
	end

endmodule

FILE: rtl/dmxtx_back.sv
module dmxtx_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dmxtx_pkg::cfg_t       cfg,
	input  logic                  cmd_valid,
	input  dmxtx_pkg::cmd_t       cmd,
	output dmxtx_pkg::back_ctrl_t ctrl,
	input  logic                  res_full,
	output logic                  res_push,
	output dmxtx_pkg::out_item_t  res
);

	localparam logic [1:0] PH_BREAK = 2'd0;
	localparam logic [1:0] PH_MAB   = 2'd1;
	localparam logic [1:0] PH_SLOTS = 2'd2;
	localparam logic [1:0] PH_WAIT  = 2'd3;
	localparam logic [dmxtx_pkg::CH_AW-1:0] CLR_LAST =
		dmxtx_pkg::CH_AW'(dmxtx_pkg::MAX_CHANNELS - 1);

	logic [7:0] mem [dmxtx_pkg::MAX_CHANNELS];
	logic [7:0] rd_q;

	logic [1:0]  ph_q, ph_d;
	logic [15:0] pt_q, pt_d;
	logic [15:0] aft_q, aft_d, aft_base;
	logic [7:0]  btim_q, btim_d;
	logic [3:0]  bidx_q, bidx_d, bidx_inc;
	logic [10:0] sw_q, sw_d;
	logic [9:0]  sc_q, sc_d;
	logic [16:0] pt_inc;
	logic [8:0]  btim_inc;
	logic        fs, ss, slot_first, line;

	logic                        clr_q;
	logic [dmxtx_pkg::CH_AW-1:0] clr_addr_q;
	logic                        take, exec_tick, exec_wr;
	logic                        mem_we;
	logic [dmxtx_pkg::CH_AW-1:0] mem_wa, ra;
	logic [7:0]                  mem_wd;

	logic [7:0]  bit_eff;
	logic [15:0] brk_eff, mab_eff;
	logic [9:0]  cnt_min, cnt_eff;

	assign take      = cmd_valid && !clr_q && !res_full;
	assign exec_tick = take && cmd.is_tick;
	assign exec_wr   = take && !cmd.is_tick && cmd.wr_en;
	assign ctrl.take     = take;
	assign ctrl.clearing = clr_q;

	// zero lengths act as one, slot count clamps to the store size
	assign bit_eff = (cfg.bit_ticks == 8'd0) ? 8'd1 : cfg.bit_ticks;
	assign brk_eff = (cfg.break_ticks == 16'd0) ? 16'd1 : cfg.break_ticks;
	assign mab_eff = (cfg.mab_ticks == 16'd0) ? 16'd1 : cfg.mab_ticks;
	assign cnt_min = (cfg.slot_count == 10'd0) ? 10'd1 : cfg.slot_count;
	assign cnt_eff = (cnt_min > dmxtx_pkg::MAX_SLOTS) ? dmxtx_pkg::MAX_SLOTS : cnt_min;

	// channel store: clearing sweep after reset, then channel writes
	assign mem_we = clr_q || exec_wr;
	assign mem_wa = clr_q ? clr_addr_q : cmd.addr;
	assign mem_wd = clr_q ? 8'h00 : cmd.level;
	assign ra     = sc_q[dmxtx_pkg::CH_AW-1:0];

	// rd_q always holds the byte of the next slot, fresh writes forwarded
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_we && (mem_wa == ra)) begin
			rd_q <= mem_wd;
		end else begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + dmxtx_pkg::CH_AW'(1);
			if (clr_addr_q == CLR_LAST) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (ph_q == PH_BREAK) begin
			line = 1'b0;
		end else if (ph_q == PH_SLOTS && bidx_q < dmxtx_pkg::BITS_PER_SLOT) begin
			line = sw_q[bidx_q];
		end else begin
			line = 1'b1;
		end
	end

	always_comb begin
		ph_d     = ph_q;
		pt_d     = pt_q;
		aft_d    = aft_q;
		btim_d   = btim_q;
		bidx_d   = bidx_q;
		sw_d     = sw_q;
		sc_d     = sc_q;
		fs       = 1'b0;
		ss       = 1'b0;
		pt_inc   = {1'b0, pt_q} + 17'd1;
		btim_inc = {1'b0, btim_q} + 9'd1;
		bidx_inc = bidx_q + 4'd1;
		slot_first = (bidx_q == 4'd0) && (btim_q == 8'd0);
		aft_base   = (ph_q == PH_SLOTS && slot_first) ? 16'd0 : aft_q;
		case (ph_q)
			PH_BREAK: begin
				fs   = (pt_q == 16'd0);
				pt_d = pt_inc[15:0];
				if (pt_inc >= {1'b0, brk_eff}) begin
					ph_d = PH_MAB;
					pt_d = '0;
				end
			end
			PH_MAB: begin
				pt_d = pt_inc[15:0];
				if (pt_inc >= {1'b0, mab_eff}) begin
					ph_d   = PH_SLOTS;
					pt_d   = '0;
					sc_d   = '0;
					sw_d   = {2'b11, dmxtx_pkg::START_CODE, 1'b0};
					bidx_d = '0;
					btim_d = '0;
				end
			end
			PH_SLOTS: begin
				ss     = slot_first;
				aft_d  = (aft_base == 16'hFFFF) ? aft_base : aft_base + 16'd1;
				btim_d = btim_inc[7:0];
				if (btim_inc >= {1'b0, bit_eff}) begin
					btim_d = '0;
					bidx_d = bidx_inc;
					if (bidx_inc >= dmxtx_pkg::BITS_PER_SLOT) begin
						bidx_d = '0;
						if (sc_q >= cnt_eff) begin
							if (aft_d >= cfg.after_frame_ticks) begin
								ph_d = PH_BREAK;
								pt_d = '0;
								sc_d = '0;
							end else begin
								ph_d = PH_WAIT;
							end
						end else begin
							sc_d = sc_q + 10'd1;
							sw_d = {2'b11, rd_q, 1'b0};
						end
					end
				end
			end
			PH_WAIT: begin
				aft_d = (aft_q == 16'hFFFF) ? aft_q : aft_q + 16'd1;
				if (aft_d >= cfg.after_frame_ticks) begin
					ph_d = PH_BREAK;
					pt_d = '0;
					sc_d = '0;
				end
			end
			default: begin
				ph_d = PH_BREAK;
				pt_d = '0;
				sc_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_BREAK;
			pt_q   <= '0;
			aft_q  <= '0;
			btim_q <= '0;
			bidx_q <= '0;
			sw_q   <= '1;
			sc_q   <= '0;
		end else if (exec_tick) begin
			ph_q   <= ph_d;
			pt_q   <= pt_d;
			aft_q  <= aft_d;
			btim_q <= btim_d;
			bidx_q <= bidx_d;
			sw_q   <= sw_d;
			sc_q   <= sc_d;
		end
	end

	assign res_push        = take;
	assign res.line        = line;
	assign res.frame_start = fs && exec_tick;
	assign res.slot_start  = ss && exec_tick;
	assign res.slot_number = sc_q;

`ifndef SYNTH
	a_clear_len: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> $past(clr_addr_q) == CLR_LAST)
		else $error("clearing sweep ended early");
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_tick && ph_q == PH_SLOTS) |-> bidx_q < dmxtx_pkg::BITS_PER_SLOT)
		else $error("bit index past stop bits");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		sc_q <= dmxtx_pkg::MAX_SLOTS)
		else $error("slot counter beyond store");
	a_start_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_tick && ss) |=> ph_q == PH_SLOTS)
		else $error("slot start left slot phase at once");
`endif

endmodule

FILE: rtl/dmxtx_outq.sv
module dmxtx_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_push,
	input  dmxtx_pkg::out_item_t res,
	output logic                 res_full,
	input  logic                 pop,
	output logic                 empty,
	output dmxtx_pkg::out_item_t result
);

	dmxtx_pkg::out_item_t ent_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       take_out;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign take_out = pop && !empty;
	assign result   = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			ent_q[wptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (res_push) begin
				wptr_q <= !wptr_q;
			end
			if (take_out) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, res_push} - {1'b0, take_out};
		end
	end

`ifndef SYNTH
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");
	a_count_move: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !take_out && cnt_q == 2'd0) |=> !empty)
		else $error("pushed result not visible");
	a_pop_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(take_out && !res_push && cnt_q == 2'd1) |=> empty)
		else $error("queue not empty after last pop");
`endif

endmodule

FILE: rtl/dmx512_frame_transmitter.sv
// DMX512 frame transmitter. After reset the block sweeps its 512-entry channel
// store to zero, one entry per clock; full stays high during the sweep,
// configuration writes are taken at any time. It then takes one item per clock
// while full is low: a tick item advances the line by one time tick (break,
// mark-after-break, start code and slots 1..slot_count, each slot a low start
// bit, eight data bits LSB first and two stop bits, bit_ticks ticks per bit),
// a write item stores one channel byte. Every item gives one result: the line
// level of that tick and the frame and slot markers. A front stage classifies
// items into a four-deep command queue, an execute stage runs the timing engine
// and the channel store (one write port, one registered read port), and a
// two-deep result queue decouples the consumer; both queues are registered.
// The store read for the next slot is done ahead of time, so writes land in the
// current frame up to the last tick of the slot before it. Write configuration
// only while no items are in flight.
module dmx512_frame_transmitter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  dmxtx_pkg::in_item_t  request,
	output logic                 empty,
	input  logic                 pop,
	output dmxtx_pkg::out_item_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data
);

	dmxtx_pkg::cfg_t       cfg_q;
	dmxtx_pkg::back_ctrl_t ctrl;
	dmxtx_pkg::cmd_t       cmd;
	dmxtx_pkg::out_item_t  res;
	logic                  cmd_valid;
	logic                  res_push, res_full;

	// register file: always ready, indexes beyond the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_ticks         <= 8'd4;
			cfg_q.break_ticks       <= 16'd130;
			cfg_q.mab_ticks         <= 16'd8;
			cfg_q.after_frame_ticks <= 16'd52;
			cfg_q.slot_count        <= 10'd512;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dmxtx_pkg::CFG_BIT_TICKS:   cfg_q.bit_ticks         <= cfg_data[7:0];
				dmxtx_pkg::CFG_BREAK_TICKS: cfg_q.break_ticks       <= cfg_data;
				dmxtx_pkg::CFG_MAB_TICKS:   cfg_q.mab_ticks         <= cfg_data;
				dmxtx_pkg::CFG_AFTER_TICKS: cfg_q.after_frame_ticks <= cfg_data;
				dmxtx_pkg::CFG_SLOT_COUNT:  cfg_q.slot_count        <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	// front: accept and classify each item
	dmxtx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.ctrl      (ctrl),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	// back: timing engine and channel store
	dmxtx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.ctrl      (ctrl),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	// hold results until the consumer pops them
	dmxtx_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

FILE: test/dmx512_frame_transmitter_test.sv
module dmx512_frame_transmitter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dmxtx_pkg::*;

	// Line phases of the frame engine, as tracked by the predictor.
	typedef enum logic [1:0] {LINE_BREAK, LINE_MAB, LINE_SLOTS, LINE_WAIT} line_phase_t;

	// One row of the directed table: either a run of items or a register write.
	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		int          reps;
		logic [2:0]  reg_idx;
		logic [15:0] reg_val;
		in_item_t    item;
		bit          typed;
		out_item_t   want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	in_item_t    request;
	logic        empty;
	logic        pop;
	out_item_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	// Register copies held by the predictor.
	logic [7:0]  cfg_bit;
	logic [15:0] cfg_break;
	logic [15:0] cfg_mab;
	logic [15:0] cfg_gap;
	logic [9:0]  cfg_slots;

	// Frame engine state held by the predictor.
	line_phase_t ph;
	logic [15:0] ph_ticks;
	logic [15:0] since_slot;
	logic [7:0]  bit_clock;
	logic [3:0]  bit_pos;
	logic [10:0] frame_bits;
	logic [9:0]  slot_no;
	logic [7:0]  chan_levels [MAX_CHANNELS];

	out_item_t   line_pending [$];
	out_item_t   oldest;
	stim_row_t   plan [$];

	bit steady;
	int mismatches;
	int ticks_sent;
	int writes_sent;
	int reg_writes;
	int frames_begun;
	int slots_begun;
	int results_checked;

	dmx512_frame_transmitter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor of the frame engine
	// ------------------------------------------------------------------

	// A zero duration behaves as one tick.
	function automatic logic [15:0] floor_one(logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	// Frame a slot byte: low start bit, data LSB first, two high stop bits.
	function automatic void load_slot_frame(logic [7:0] lvl);
		frame_bits = {2'b11, lvl, 1'b0};
		bit_pos = 4'd0;
		bit_clock = 8'd0;
	endfunction

	function automatic void begin_break();
		ph = LINE_BREAK;
		ph_ticks = 16'd0;
		slot_no = 10'd0;
	endfunction

	// Advance the predicted engine by one item and return the result it gives.
	function automatic out_item_t predict_line(in_item_t it);
		out_item_t  r;
		logic [9:0] last_slot;
		r = '0;
		case (ph)
		LINE_BREAK: r.line = 1'b0;
		LINE_SLOTS: r.line = (bit_pos < BITS_PER_SLOT) ? frame_bits[bit_pos] : 1'b0;
		default:    r.line = 1'b1;
		endcase
		r.slot_number = slot_no;

		// A write stores the byte and leaves time alone.
		if (it.action == ACT_WRITE) begin
			chan_levels[it.channel] = it.level;
			return r;
		end

		// Clamp the slot count into 1..MAX_SLOTS.
		last_slot = (cfg_slots == 10'd0) ? 10'd1 :
			(cfg_slots > MAX_SLOTS) ? MAX_SLOTS : cfg_slots;

		case (ph)
		LINE_BREAK: begin
			r.frame_start = (ph_ticks == 16'd0);
			ph_ticks++;
			if (ph_ticks >= floor_one(cfg_break)) begin
				ph = LINE_MAB;
				ph_ticks = 16'd0;
			end
		end
		LINE_MAB: begin
			ph_ticks++;
			if (ph_ticks >= floor_one(cfg_mab)) begin
				ph = LINE_SLOTS;
				ph_ticks = 16'd0;
				slot_no = 10'd0;
				load_slot_frame(START_CODE);
			end
		end
		LINE_SLOTS: begin
			if (bit_pos == 4'd0 && bit_clock == 8'd0) begin
				r.slot_start = 1'b1;
				since_slot = 16'd0;
			end
			if (since_slot != 16'hFFFF)
				since_slot++;
			bit_clock++;
			if (bit_clock >= floor_one({8'd0, cfg_bit})) begin
				bit_clock = 8'd0;
				bit_pos++;
				if (bit_pos >= BITS_PER_SLOT) begin
					if (slot_no >= last_slot) begin
						// Last slot done: break now or hold mark until the gap is met.
						bit_pos = 4'd0;
						if (since_slot >= cfg_gap)
							begin_break();
						else
							ph = LINE_WAIT;
					end else begin
						// Slot n carries channel n-1, read as its start bit begins.
						slot_no++;
						load_slot_frame(chan_levels[slot_no - 10'd1]);
					end
				end
			end
		end
		LINE_WAIT: begin
			if (since_slot != 16'hFFFF)
				since_slot++;
			if (since_slot >= cfg_gap)
				begin_break();
		end
		default: begin_break();
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Table builders
	// ------------------------------------------------------------------

	function automatic in_item_t mk_in(logic act, logic [8:0] ch, logic [7:0] lv);
		in_item_t it;
		it.action = act;
		it.channel = ch;
		it.level = lv;
		return it;
	endfunction

	function automatic out_item_t mk_out(logic ln, logic fs, logic ss, logic [9:0] sn);
		out_item_t o;
		o.line = ln;
		o.frame_start = fs;
		o.slot_start = ss;
		o.slot_number = sn;
		return o;
	endfunction

	function automatic void row_item(in_item_t it, int reps, bit typed, out_item_t want);
		stim_row_t row;
		row = '{ROW_ITEM, reps, 3'd0, 16'd0, it, typed, want};
		plan.push_back(row);
	endfunction

	function automatic void row_reg(logic [2:0] idx, logic [15:0] val);
		stim_row_t row;
		row = '{ROW_REG, 0, idx, val, '0, 1'b0, '0};
		plan.push_back(row);
	endfunction

	// ------------------------------------------------------------------
	// Drivers and checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Offer one item, idling at random first; record its expected result on accept.
	// A typed row supplies the expected result, all other items take the predictor's.
	task automatic send_item(in_item_t it, bit typed, out_item_t want);
		out_item_t predicted;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 13) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		request <= it;
		do @(posedge clk); while (full);
		predicted = predict_line(it);
		if (!typed)
			want = predicted;
		line_pending.push_back(want);
		if (it.action == ACT_TICK)
			ticks_sent++;
		else
			writes_sent++;
		frames_begun += want.frame_start;
		slots_begun += want.slot_start;
	endtask

	// Hold the sender until every expected result is back, then let the
	// pipeline settle before touching registers.
	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (line_pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register over the configuration channel and mirror it.
	task automatic write_register(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		CFG_BIT_TICKS:   cfg_bit = val[7:0];
		CFG_BREAK_TICKS: cfg_break = val;
		CFG_MAB_TICKS:   cfg_mab = val;
		CFG_AFTER_TICKS: cfg_gap = val;
		CFG_SLOT_COUNT:  cfg_slots = val[9:0];
		default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Consumer side: stall at random except during the steady stretch.
	always @(negedge clk)
		pop <= arst_n && (steady || $urandom_range(99) >= 13);

	// Compare every accepted result with the oldest expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			results_checked++;
			if (line_pending.size() == 0) begin
				report_mismatch("result with nothing pending, slot_number",
					result.slot_number, 0);
			end else begin
				oldest = line_pending.pop_front();
				if (result.line !== oldest.line)
					report_mismatch("line", result.line, oldest.line);
				if (result.frame_start !== oldest.frame_start)
					report_mismatch("frame_start", result.frame_start, oldest.frame_start);
				if (result.slot_start !== oldest.slot_start)
					report_mismatch("slot_start", result.slot_start, oldest.slot_start);
				if (result.slot_number !== oldest.slot_number)
					report_mismatch("slot_number", result.slot_number, oldest.slot_number);
			end
		end
	end

	// Watchdog: the limit leaves ample margin over a correct run, including the
	// store sweep after reset.
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	initial begin
		int          p;
		int          n;
		logic [7:0]  bt;
		logic [15:0] brk;
		logic [15:0] mab_len;
		logic [15:0] gap;
		logic [9:0]  sc;
		in_item_t    it;

		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		mismatches = 0;
		ticks_sent = 0;
		writes_sent = 0;
		reg_writes = 0;
		frames_begun = 0;
		slots_begun = 0;
		results_checked = 0;

		// Predictor starts from the reset state: defaults, break phase, empty store.
		cfg_bit = 8'd4;
		cfg_break = 16'd130;
		cfg_mab = 16'd8;
		cfg_gap = 16'd52;
		cfg_slots = 10'd512;
		ph = LINE_BREAK;
		ph_ticks = 16'd0;
		since_slot = 16'd0;
		bit_clock = 8'd0;
		bit_pos = 4'd0;
		frame_bits = 11'h7FF;
		slot_no = 10'd0;
		foreach (chan_levels[i])
			chan_levels[i] = 8'd0;

		// Directed table. The first tick after reset opens a break. Writes
		// answer with the coming line level. Shrinking a running phase below
		// its elapsed time ends it on the next tick; zero lengths and a zero
		// slot count act as one. Slot 1 carries channel 0, written beforehand.
		row_item(mk_in(ACT_TICK, 9'h1FF, 8'hFF), 1, 1, mk_out(1'b0, 1'b1, 1'b0, 10'd0));
		row_item(mk_in(ACT_WRITE, 9'd0, 8'hFF), 1, 1, mk_out(1'b0, 1'b0, 1'b0, 10'd0));
		row_item(mk_in(ACT_WRITE, 9'h1FF, 8'h00), 1, 1, mk_out(1'b0, 1'b0, 1'b0, 10'd0));
		row_item(mk_in(ACT_TICK, 9'd0, 8'd0), 1, 1, mk_out(1'b0, 1'b0, 1'b0, 10'd0));
		row_reg(CFG_BREAK_TICKS, 16'd0);
		row_item(mk_in(ACT_TICK, 9'd0, 8'd0), 1, 1, mk_out(1'b0, 1'b0, 1'b0, 10'd0));
		row_reg(CFG_MAB_TICKS, 16'd0);
		row_reg(CFG_BIT_TICKS, 16'd0);
		row_reg(CFG_SLOT_COUNT, 16'd0);
		row_reg(CFG_AFTER_TICKS, 16'd0);
		row_item(mk_in(ACT_TICK, 9'd0, 8'd0), 1, 1, mk_out(1'b1, 1'b0, 1'b0, 10'd0));
		row_item(mk_in(ACT_TICK, 9'd0, 8'd0), 1, 1, mk_out(1'b0, 1'b0, 1'b1, 10'd0));
		row_item(mk_in(ACT_TICK, 9'd0, 8'd0), 4, 0, '0);
		row_item(mk_in(ACT_WRITE, 9'd1, 8'h5A), 1, 0, '0);
		row_item(mk_in(ACT_TICK, 9'd0, 8'd0), 6, 0, '0);
		row_item(mk_in(ACT_TICK, 9'd0, 8'd0), 1, 1, mk_out(1'b0, 1'b0, 1'b1, 10'd1));
		row_item(mk_in(ACT_TICK, 9'd0, 8'd0), 10, 0, '0);
		row_item(mk_in(ACT_TICK, 9'd0, 8'd0), 1, 1, mk_out(1'b0, 1'b1, 1'b0, 10'd0));

		// Release reset on a falling edge.
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Walk the table; drain before every register write.
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				wait_drained();
				write_register(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				repeat (plan[i].reps)
					send_item(plan[i].item, plan[i].typed, plan[i].want);
			end
		end

		// Random part: twelve settings, each written while idle, then a batch
		// of mostly ticks with writes mixed in. Short timings and few slots
		// keep frames turning over; selected settings push registers to their
		// extremes, and the following setting pulls them back mid-phase.
		for (p = 0; p < 12; p++) begin
			bt = 8'($urandom_range(3));
			brk = 16'($urandom_range(4));
			mab_len = 16'($urandom_range(3));
			gap = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(40));
			sc = 10'($urandom_range(6));
			case (p)
			2:  brk = 16'hFFFF;
			4:  bt = 8'hFF;
			6:  begin
				gap = 16'hFFFF;
				sc = 10'd1;
			end
			8:  mab_len = 16'hFFFF;
			9:  sc = 10'h3FF;
			10: sc = MAX_SLOTS;
			default: ;
			endcase

			wait_drained();
			// Run one whole batch with no idling on either side.
			steady = (p == 5);
			write_register(CFG_BIT_TICKS, {8'd0, bt});
			write_register(CFG_BREAK_TICKS, brk);
			write_register(CFG_MAB_TICKS, mab_len);
			write_register(CFG_AFTER_TICKS, gap);
			write_register(CFG_SLOT_COUNT, {6'd0, sc});

			for (n = 0; n < 115; n++) begin
				// Aim most writes at the low channels that short frames send.
				it.action = ($urandom_range(99) < 20) ? ACT_WRITE : ACT_TICK;
				it.channel = ($urandom_range(9) < 7) ? 9'($urandom_range(7)) :
					9'($urandom_range(511));
				it.level = 8'($urandom_range(255));
				send_item(it, 1'b0, '0);
			end
		end

		// Drain, then give the pipeline time to show any stray result.
		steady = 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);

		$display("Sent %0d tick items and %0d channel writes; %0d register writes.",
			ticks_sent, writes_sent, reg_writes);
		$display("Frames begun: %0d, slots begun: %0d, results compared: %0d.",
			frames_begun, slots_begun, results_checked);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: dmx512_frame_transmitter.f
rtl/dmxtx_pkg.sv
rtl/dmxtx_front.sv
rtl/dmxtx_back.sv
rtl/dmxtx_outq.sv
rtl/dmx512_frame_transmitter.sv
test/dmx512_frame_transmitter_test.sv
